// ===== sv/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, operation and status codes, and the command, status and
// result types of the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    localparam int OP_W    = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int INDEX_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic do_insert;   // insert at position this cycle
        logic do_delete;   // delete at position this cycle
        logic list_empty;  // emit the empty-list result
        logic list_start;  // rewind the listing index
        logic list_step;   // emit cell 0 and rotate the row
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic list_last;
    } t_stat;

    // One result item
    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] entry_value;
        logic [INDEX_W-1:0]       entry_index;
        logic                     last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/pal_in_if.sv =====
// ----------------------------------------------------------------------------
// pal_in_if
// Request channel: operation, position and value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_in_if;
    logic                              valid;
    logic                              ready;
    logic [pal_pkg::OP_W-1:0]          operation;
    logic [pal_pkg::POS_W-1:0]         position;
    logic signed [pal_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output operation, output position,
                    output item_value, input ready);
    modport sink   (input valid, input operation, input position,
                    input item_value, output ready);
endinterface

`default_nettype wire

// ===== sv/pal_out_if.sv =====
// ----------------------------------------------------------------------------
// pal_out_if
// Result channel: status, entry value, entry index and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_out_if;
    logic                              valid;
    logic                              ready;
    logic [pal_pkg::ST_W-1:0]          status;
    logic signed [pal_pkg::DATA_W-1:0] entry_value;
    logic [pal_pkg::INDEX_W-1:0]       entry_index;
    logic                              last;

    modport source (output valid, output status, output entry_value,
                    output entry_index, output last, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input entry_index, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed 32-bit values with insert/delete at a 1-based
// position and a full listing.
//
// Usage: requests enter on i_in (operation, position, item_value), results
// leave on o_out (status, entry_value, entry_index, last). A transfer happens
// when valid and ready are both high.
// Insert and delete shift the entry cells from the position onward in the
// accept cycle; their single result is registered in the output buffer, and
// a new insert or delete can be taken every cycle while the buffer has room.
// A listing rotates the row one place per cycle while the buffer has room,
// emitting cell 0 each time: a list of N entries gives N results and no
// request is taken until its last entry is emitted; an empty list gives one
// result. Operation code 3 is taken and produces nothing.
// Results pass through a two-entry output buffer; while the receiver stalls
// the listing pauses and i_in.ready drops once the buffer holds two results.
// Reset (synchronous, active low) empties the list and the buffer; entry
// cells are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pal_in_if.sink    i_in,
    pal_out_if.source o_out
);
    import pal_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_result;
    logic    w_push;
    logic    w_room;

    pal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_room      (w_room),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_position   (i_in.position),
        .i_item_value (i_in.item_value),
        .o_stat       (w_stat),
        .o_push       (w_push),
        .o_result     (w_result)
    );

    pal_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_room   (w_room),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== sv/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller: accepts requests and lists one entry per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [pal_pkg::OP_W-1:0] i_operation,
    output logic                          o_in_ready,
    input  wire logic                     i_room,
    input  wire pal_pkg::t_stat           i_stat,
    output pal_pkg::t_cmd                 o_cmd
);
    import pal_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    // No request is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE) && i_room;
    assign w_accept   = i_in_valid && o_in_ready;

    // Command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.do_insert  = w_accept && (i_operation == OP_INSERT);
        o_cmd.do_delete  = w_accept && (i_operation == OP_DELETE);
        o_cmd.list_empty = w_accept && (i_operation == OP_LIST) && i_stat.count_zero;
        o_cmd.list_start = w_accept && (i_operation == OP_LIST) && !i_stat.count_zero;
        o_cmd.list_step  = (r_state == S_LIST) && i_room;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.list_start) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (o_cmd.list_step && i_stat.list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pal_datapath.sv =====
// ----------------------------------------------------------------------------
// pal_datapath
// Row of entry cells with live count; shifts for insert and delete, rotates
// for listing, and forms the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pal_pkg::t_cmd                     i_cmd,
    input  wire logic [pal_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pal_pkg::DATA_W-1:0] i_item_value,
    output pal_pkg::t_stat                         o_stat,
    output logic                                   o_push,
    output pal_pkg::t_result                       o_result
);
    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] r_cells [CAPACITY];
    logic signed [DATA_W-1:0] n_cells [CAPACITY];
    logic signed [DATA_W-1:0] w_prev  [CAPACITY];
    logic signed [DATA_W-1:0] w_next  [CAPACITY];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_list_idx;
    logic [CW-1:0]            w_list_num;
    logic [7:0]               w_pos8;
    logic [7:0]               w_cnt8;
    logic [7:0]               w_slot8;
    logic                     w_ins_pos_ok;
    logic                     w_ins_full;
    logic                     w_ins_ok;
    logic                     w_del_ok;

    // Neighbor taps of each cell
    for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign w_prev[g] = r_cells[g];
        end else begin : g_mid
            assign w_prev[g] = r_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next[g] = r_cells[g];
        end else begin : g_inner
            assign w_next[g] = r_cells[g+1];
        end
    end

    // Position checks
    assign w_pos8       = {1'b0, i_position};
    assign w_cnt8       = 8'(r_count);
    assign w_slot8      = w_pos8 - 8'd1;
    assign w_ins_pos_ok = (w_pos8 != 8'd0) && (w_pos8 <= w_cnt8 + 8'd1);
    assign w_ins_full   = (w_cnt8 == 8'(CAPACITY));
    assign w_ins_ok     = w_ins_pos_ok && !w_ins_full;
    assign w_del_ok     = (w_pos8 != 8'd0) && (w_pos8 <= w_cnt8);

    // Per-cell next value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (i_cmd.do_insert && w_ins_ok) begin
                if (8'(i) == w_slot8) begin
                    n_cells[i] = i_item_value;
                end else if (8'(i) > w_slot8) begin
                    n_cells[i] = w_prev[i];
                end
            end else if (i_cmd.do_delete && w_del_ok) begin
                if (8'(i) >= w_slot8) begin
                    n_cells[i] = w_next[i];
                end
            end else if (i_cmd.list_step) begin
                if (8'(i) == w_cnt8 - 8'd1) begin
                    n_cells[i] = r_cells[0];
                end else begin
                    n_cells[i] = w_next[i];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert && w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.do_delete && w_del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_list_idx <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.list_start) begin
                r_list_idx <= '0;
            end else if (i_cmd.list_step) begin
                r_list_idx <= w_list_num;
            end
        end
    end

    // Status toward the controller
    assign w_list_num        = r_list_idx + CW'(1);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.list_last  = (w_list_num == r_count);

    // Result formation
    assign o_push = i_cmd.do_insert || i_cmd.do_delete || i_cmd.list_empty
                    || i_cmd.list_step;

    always_comb begin
        o_result             = '0;
        o_result.last        = 1'b1;
        o_result.entry_index = INDEX_W'(n_count);
        if (i_cmd.do_insert) begin
            o_result.status = !w_ins_pos_ok ? ST_BAD_POS : (w_ins_full ? ST_FULL : ST_OK);
        end else if (i_cmd.do_delete) begin
            o_result.status = w_del_ok ? ST_OK : ST_BAD_POS;
        end else if (i_cmd.list_empty) begin
            o_result.status      = ST_EMPTY;
            o_result.entry_index = '0;
        end else begin
            o_result.status      = ST_OK;
            o_result.entry_value = r_cells[0];
            o_result.entry_index = INDEX_W'(w_list_num);
            o_result.last        = o_stat.list_last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        8'(r_count) <= 8'(CAPACITY))
        else $error("live count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_insert && w_ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the count");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_delete && w_del_ok) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("accepted delete did not shrink the count");

endmodule

`default_nettype wire

// ===== sv/pal_outbuf.sv =====
// ----------------------------------------------------------------------------
// pal_outbuf
// Two-entry output buffer (output register plus skid entry) on the result
// channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pal_pkg::t_result i_result,
    output logic                  o_room,
    pal_out_if.source             o_out
);
    import pal_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop  = r_main_valid && o_out.ready;
    assign o_room = !r_skid_valid;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop && r_skid_valid) begin
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push && (w_pop || !r_main_valid)) begin
            r_main <= i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid       = r_main_valid;
    assign o_out.status      = r_main.status;
    assign o_out.entry_value = r_main.entry_value;
    assign o_out.entry_index = r_main.entry_index;
    assign o_out.last        = r_main.last;

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without output entry");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into a full buffer");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_main_valid) |=> r_main_valid)
        else $error("pushed result lost");

endmodule

`default_nettype wire
